[sv/assert_macros.svh]
// Assertion macros used by the checker file rti_checker.sv.
// No dependencies; expects clk_i and rst_ni in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define RTI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define RTI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[sv/rti_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and register codes for the ray-triangle intersection block.
// No dependencies.
package rti_pkg;
  localparam int CFG_DW    = 60;
  localparam int CFG_IDX_W = 3;
  localparam int EPS_BITS  = 20;
  localparam int UV_BITS   = 16;
  localparam int UVW       = UV_BITS + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_VTX_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VTX_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VTX_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EPS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CULL  = 3'd4;
endpackage

[sv/ray_triangle_intersect_top.sv]
`timescale 1ns / 1ps
// Moller-Trumbore ray against one configured triangle, fully pipelined.
// Depends on rti_pkg and rti_div.
//
//  channel   direction  handshake                 payload
//  cfg       in         cfg_we_i                  cfg_idx_i, cfg_data_i
//  ray       in         in_valid_i / in_stall_o   origin_*_i, dir_*_i
//  result    out        out_valid_o / out_stall_i hit_o, dist_res_o, bary_*_o, hit_*_o
//
// One ray enters every cycle while the result is not stalled; the pipeline
// includes the bit-per-stage dividers for t, u and v.
// A stalled result freezes the whole pipeline: in_stall_o = out_valid_o & out_stall_i.
// Reset clears valid bits and configuration (epsilon resets to 1); no clearing pass.
module ray_triangle_intersect_top #(
  parameter int COORD_BITS = 20,
  parameter int FRAC_BITS  = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rti_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rti_pkg::CFG_DW-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [COORD_BITS-1:0]      origin_x_i,
  input  logic signed [COORD_BITS-1:0]      origin_y_i,
  input  logic signed [COORD_BITS-1:0]      origin_z_i,
  input  logic signed [COORD_BITS-1:0]      dir_x_i,
  input  logic signed [COORD_BITS-1:0]      dir_y_i,
  input  logic signed [COORD_BITS-1:0]      dir_z_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              hit_o,
  output logic signed [COORD_BITS-1:0]      dist_res_o,
  output logic [rti_pkg::UVW-1:0]           bary_u_o,
  output logic [rti_pkg::UVW-1:0]           bary_v_o,
  output logic signed [COORD_BITS-1:0]      hit_x_o,
  output logic signed [COORD_BITS-1:0]      hit_y_o,
  output logic signed [COORD_BITS-1:0]      hit_z_o
);
  import rti_pkg::*;

  localparam int CW   = COORD_BITS;
  localparam int EW   = CW + 1;
  localparam int PW   = CW + EW + 1 - FRAC_BITS;
  localparam int QW   = 2 * EW + 1 - FRAC_BITS;
  localparam int SW   = EW + QW + 2;
  localparam int DQ   = EPS_BITS + 1;
  localparam int NW   = SW + DQ;
  localparam int CMPW = ((SW > EPS_BITS + FRAC_BITS) ? SW : EPS_BITS + FRAC_BITS) + 1;
  localparam int VW   = 3 * CW;
  localparam int MW   = UV_BITS + 2 + EW;
  localparam int AW   = MW + 2;
  localparam int HPW  = AW - UV_BITS + 1;
  localparam logic [DQ-1:0] CMAXQ = DQ'((64'd1 << (CW - 1)) - 64'd1);
  localparam logic signed [HPW-1:0] HMAX = HPW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [HPW-1:0] HMIN = HPW'(-(64'sd1 <<< (CW - 1)));
  localparam logic signed [AW-1:0]  HALF = AW'(64'sd1 <<< (UV_BITS - 1));

  // configuration
  logic [CFG_DW-1:0]   vtx_a_q, vtx_b_q, vtx_c_q;
  logic [EPS_BITS-1:0] eps_q;
  logic                cull_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vtx_a_q <= '0;
      vtx_b_q <= '0;
      vtx_c_q <= '0;
      eps_q   <= EPS_BITS'(1);
      cull_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_VTX_A: vtx_a_q <= cfg_data_i;
        CFG_VTX_B: vtx_b_q <= cfg_data_i;
        CFG_VTX_C: vtx_c_q <= cfg_data_i;
        CFG_EPS:   eps_q   <= cfg_data_i[EPS_BITS-1:0];
        CFG_CULL:  cull_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [VW-1:0]          va, vb, vc;
  logic signed [CW-1:0]   a [3];
  logic signed [CW-1:0]   b [3];
  logic signed [CW-1:0]   c [3];
  logic signed [EW-1:0]   e1 [3];
  logic signed [EW-1:0]   e2 [3];

  always_comb begin
    va = VW'(vtx_a_q);
    vb = VW'(vtx_b_q);
    vc = VW'(vtx_c_q);
    for (int i = 0; i < 3; i++) begin
      a[i]  = signed'(va[i*CW +: CW]);
      b[i]  = signed'(vb[i*CW +: CW]);
      c[i]  = signed'(vc[i*CW +: CW]);
      e1[i] = EW'(b[i]) - EW'(a[i]);
      e2[i] = EW'(c[i]) - EW'(a[i]);
    end
  end

  // pipeline advance
  logic en;
  logic out_vld_q;
  assign en         = !out_vld_q || !out_stall_i;
  assign in_stall_o = !en;

  // stage 1: input register
  logic                 v1_q;
  logic signed [CW-1:0] o1_q [3];
  logic signed [CW-1:0] k1_q [3];

  // stage 2: cross-product terms
  logic                      v2_q;
  logic signed [EW-1:0]      tv2_q [3];
  logic signed [CW-1:0]      k2_q [3];
  logic signed [CW+EW-1:0]   pp2_q [6];
  logic signed [2*EW-1:0]    qp2_q [6];
  logic signed [EW-1:0]      tv2_d [3];
  logic signed [CW+EW-1:0]   pp2_d [6];
  logic signed [2*EW-1:0]    qp2_d [6];

  always_comb begin
    for (int i = 0; i < 3; i++) tv2_d[i] = EW'(o1_q[i]) - EW'(a[i]);
    pp2_d[0] = k1_q[1] * e2[2];
    pp2_d[1] = k1_q[2] * e2[1];
    pp2_d[2] = k1_q[2] * e2[0];
    pp2_d[3] = k1_q[0] * e2[2];
    pp2_d[4] = k1_q[0] * e2[1];
    pp2_d[5] = k1_q[1] * e2[0];
    qp2_d[0] = tv2_d[1] * e1[2];
    qp2_d[1] = tv2_d[2] * e1[1];
    qp2_d[2] = tv2_d[2] * e1[0];
    qp2_d[3] = tv2_d[0] * e1[2];
    qp2_d[4] = tv2_d[0] * e1[1];
    qp2_d[5] = tv2_d[1] * e1[0];
  end

  // stage 3: P = K x e2, Q = T x e1, floored to Q format
  logic                      v3_q;
  logic signed [EW-1:0]      tv3_q [3];
  logic signed [CW-1:0]      k3_q [3];
  logic signed [PW-1:0]      p3_q [3];
  logic signed [QW-1:0]      q3_q [3];
  logic signed [CW+EW:0]     pdif [3];
  logic signed [2*EW:0]      qdif [3];
  logic signed [PW-1:0]      p3_d [3];
  logic signed [QW-1:0]      q3_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pdif[i] = (CW+EW+1)'(pp2_q[2*i]) - (CW+EW+1)'(pp2_q[2*i+1]);
      qdif[i] = (2*EW+1)'(qp2_q[2*i]) - (2*EW+1)'(qp2_q[2*i+1]);
      p3_d[i] = PW'(pdif[i] >>> FRAC_BITS);
      q3_d[i] = QW'(qdif[i] >>> FRAC_BITS);
    end
  end

  // stage 4: dot-product terms
  logic                      v4_q;
  logic signed [EW+PW-1:0]   dt4_q [3];
  logic signed [EW+PW-1:0]   ut4_q [3];
  logic signed [CW+QW-1:0]   vt4_q [3];
  logic signed [EW+QW-1:0]   tt4_q [3];

  // stage 5: det and numerators
  logic                      v5_q;
  logic signed [SW-1:0]      det5_q, un5_q, vn5_q, tn5_q;
  logic signed [SW-1:0]      det5_d, un5_d, vn5_d, tn5_d;

  always_comb begin
    det5_d = SW'(dt4_q[0]) + SW'(dt4_q[1]) + SW'(dt4_q[2]);
    un5_d  = SW'(ut4_q[0]) + SW'(ut4_q[1]) + SW'(ut4_q[2]);
    vn5_d  = SW'(vt4_q[0]) + SW'(vt4_q[1]) + SW'(vt4_q[2]);
    tn5_d  = SW'(tt4_q[0]) + SW'(tt4_q[1]) + SW'(tt4_q[2]);
  end

  // stage 6: determinant test and sign fold
  logic                      v6_q, miss6_q, miss6_d;
  logic signed [SW-1:0]      det6_q, un6_q, vn6_q, tn6_q;
  logic signed [CMPW-1:0]    eps_det, det_c;
  logic                      dneg;

  always_comb begin
    eps_det = $signed(CMPW'({eps_q, {FRAC_BITS{1'b0}}}));
    det_c   = CMPW'(det5_q);
    dneg    = det5_q < 0;
    if (cull_q) miss6_d = det_c < eps_det;
    else        miss6_d = (det_c > -eps_det) && (det_c < eps_det);
    if (det5_q == '0) miss6_d = 1'b1;
  end

  // stage 7: range tests
  logic                      v7_q, miss7_q, tovf7_q, miss7_d, tovf7_d;
  logic signed [SW-1:0]      det7_q, un7_q, vn7_q, tn7_q;
  logic signed [SW:0]        uvsum;
  logic signed [NW-1:0]      tn_x, det_sh;

  always_comb begin
    uvsum   = (SW+1)'(un6_q) + (SW+1)'(vn6_q);
    tn_x    = NW'(tn6_q);
    det_sh  = NW'(det6_q) <<< (DQ - FRAC_BITS);
    tovf7_d = tn_x >= det_sh;
    miss7_d = miss6_q || (un6_q < 0) || (un6_q > det6_q) || (vn6_q < 0) ||
              (uvsum > (SW+1)'(det6_q)) || (tn6_q < 0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        tv2_q[i] <= tv2_d[i];
        k2_q[i]  <= k1_q[i];
        tv3_q[i] <= tv2_q[i];
        k3_q[i]  <= k2_q[i];
        p3_q[i]  <= p3_d[i];
        q3_q[i]  <= q3_d[i];
        dt4_q[i] <= e1[i] * p3_q[i];
        ut4_q[i] <= tv3_q[i] * p3_q[i];
        vt4_q[i] <= k3_q[i] * q3_q[i];
        tt4_q[i] <= e2[i] * q3_q[i];
      end
      o1_q[0] <= origin_x_i;
      o1_q[1] <= origin_y_i;
      o1_q[2] <= origin_z_i;
      k1_q[0] <= dir_x_i;
      k1_q[1] <= dir_y_i;
      k1_q[2] <= dir_z_i;
      for (int i = 0; i < 6; i++) begin
        pp2_q[i] <= pp2_d[i];
        qp2_q[i] <= qp2_d[i];
      end
      det5_q  <= det5_d;
      un5_q   <= un5_d;
      vn5_q   <= vn5_d;
      tn5_q   <= tn5_d;
      miss6_q <= miss6_d;
      det6_q  <= dneg ? -det5_q : det5_q;
      un6_q   <= dneg ? -un5_q : un5_q;
      vn6_q   <= dneg ? -vn5_q : vn5_q;
      tn6_q   <= dneg ? -tn5_q : tn5_q;
      miss7_q <= miss7_d;
      tovf7_q <= tovf7_d;
      det7_q  <= det6_q;
      un7_q   <= un6_q;
      vn7_q   <= vn6_q;
      tn7_q   <= tn6_q;
    end
  end

  // dividers
  logic [NW-1:0] num_t, num_u, num_v;
  logic [SW-1:0] den;
  logic [DQ-1:0] tq, uq, vq;

  assign den   = $unsigned(det7_q);
  assign num_t = NW'($unsigned(tn7_q)) << FRAC_BITS;
  assign num_u = NW'($unsigned(un7_q)) << UV_BITS;
  assign num_v = NW'($unsigned(vn7_q)) << UV_BITS;

  rti_div #(.DEN_W(SW), .QUO_W(DQ)) u_div_t (
    .clk_i(clk_i), .en_i(en), .num_i(num_t), .den_i(den), .quo_o(tq)
  );
  rti_div #(.DEN_W(SW), .QUO_W(DQ)) u_div_u (
    .clk_i(clk_i), .en_i(en), .num_i(num_u), .den_i(den), .quo_o(uq)
  );
  rti_div #(.DEN_W(SW), .QUO_W(DQ)) u_div_v (
    .clk_i(clk_i), .en_i(en), .num_i(num_v), .den_i(den), .quo_o(vq)
  );

  logic vd_q [DQ];
  logic md_q [DQ];
  logic od_q [DQ];

  always_ff @(posedge clk_i) begin
    if (en) begin
      md_q[0] <= miss7_q;
      od_q[0] <= tovf7_q;
      for (int j = 1; j < DQ; j++) begin
        md_q[j] <= md_q[j-1];
        od_q[j] <= od_q[j-1];
      end
    end
  end

  // stage p1: distance test, hit-point products
  logic                    vp_q, hitp_q, hitp_d;
  logic signed [CW-1:0]    distp_q, distp_d;
  logic [UVW-1:0]          up_q, vp_u_q;
  logic signed [MW-1:0]    mu_q [3];
  logic signed [MW-1:0]    mv_q [3];
  logic [UVW-1:0]          u17, v17;

  always_comb begin
    u17    = uq[UVW-1:0];
    v17    = vq[UVW-1:0];
    hitp_d = !md_q[DQ-1] && (od_q[DQ-1] || (tq >= DQ'(eps_q)));
    if (od_q[DQ-1] || (tq > CMAXQ)) distp_d = signed'(CMAXQ[CW-1:0]);
    else                            distp_d = signed'(tq[CW-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hitp_q  <= hitp_d;
      distp_q <= distp_d;
      up_q    <= u17;
      vp_u_q  <= v17;
      for (int i = 0; i < 3; i++) begin
        mu_q[i] <= $signed({1'b0, u17}) * e1[i];
        mv_q[i] <= $signed({1'b0, v17}) * e2[i];
      end
    end
  end

  // output stage: hit point, zero on miss
  logic signed [AW-1:0]  acc [3];
  logic signed [HPW-1:0] hp [3];
  logic signed [CW-1:0]  hs [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = AW'(mu_q[i]) + AW'(mv_q[i]) + HALF;
      hp[i]  = HPW'(acc[i] >>> UV_BITS) + HPW'(a[i]);
      if (hp[i] > HMAX)      hs[i] = HMAX[CW-1:0];
      else if (hp[i] < HMIN) hs[i] = HMIN[CW-1:0];
      else                   hs[i] = hp[i][CW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_o      <= hitp_q;
      dist_res_o <= hitp_q ? distp_q : '0;
      bary_u_o   <= hitp_q ? up_q : '0;
      bary_v_o   <= hitp_q ? vp_u_q : '0;
      hit_x_o    <= hitp_q ? hs[0] : '0;
      hit_y_o    <= hitp_q ? hs[1] : '0;
      hit_z_o    <= hitp_q ? hs[2] : '0;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      v5_q      <= 1'b0;
      v6_q      <= 1'b0;
      v7_q      <= 1'b0;
      for (int j = 0; j < DQ; j++) vd_q[j] <= 1'b0;
      vp_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      v1_q      <= in_valid_i;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      v4_q      <= v3_q;
      v5_q      <= v4_q;
      v6_q      <= v5_q;
      v7_q      <= v6_q;
      vd_q[0]   <= v7_q;
      for (int j = 1; j < DQ; j++) vd_q[j] <= vd_q[j-1];
      vp_q      <= vd_q[DQ-1];
      out_vld_q <= vp_q;
    end
  end

  assign out_valid_o = out_vld_q;
endmodule

[sv/rti_div.sv]
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per register stage.
// Standalone; instantiated by ray_triangle_intersect_top.
module rti_div #(
  parameter int DEN_W = 56,
  parameter int QUO_W = 21
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [DEN_W+QUO_W-1:0] num_i,
  input  logic [DEN_W-1:0]       den_i,
  output logic [QUO_W-1:0]       quo_o
);
  localparam int NW = DEN_W + QUO_W;

  logic [NW-1:0]    rem_q [QUO_W];
  logic [NW-1:0]    rem_d [QUO_W];
  logic [NW-1:0]    r_in  [QUO_W];
  logic [NW-1:0]    dsh   [QUO_W];
  logic [NW:0]      diff  [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [DEN_W-1:0] d_in  [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];
  logic [QUO_W-1:0] quo_d [QUO_W];
  logic [QUO_W-1:0] q_in  [QUO_W];

  always_comb begin
    for (int j = 0; j < QUO_W; j++) begin
      if (j == 0) begin
        r_in[j] = num_i;
        d_in[j] = den_i;
        q_in[j] = '0;
      end else begin
        r_in[j] = rem_q[j-1];
        d_in[j] = den_q[j-1];
        q_in[j] = quo_q[j-1];
      end
      dsh[j]  = NW'(d_in[j]) << (QUO_W - 1 - j);
      diff[j] = {1'b0, r_in[j]} - {1'b0, dsh[j]};
      if (!diff[j][NW]) begin
        rem_d[j] = diff[j][NW-1:0];
        quo_d[j] = q_in[j] | (QUO_W'(1) << (QUO_W - 1 - j));
      end else begin
        rem_d[j] = r_in[j];
        quo_d[j] = q_in[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < QUO_W; j++) begin
        rem_q[j] <= rem_d[j];
        den_q[j] <= d_in[j];
        quo_q[j] <= quo_d[j];
      end
    end
  end

  assign quo_o = quo_q[QUO_W-1];
endmodule

[sv/rti_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for ray_triangle_intersect_top, attached by bind.
// Depends on rti_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rti_checker #(
  parameter int COORD_BITS = 20
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          hit_o,
  input logic signed [COORD_BITS-1:0]  dist_res_o,
  input logic [rti_pkg::UVW-1:0]       bary_u_o,
  input logic [rti_pkg::UVW-1:0]       bary_v_o,
  input logic signed [COORD_BITS-1:0]  hit_x_o,
  input logic signed [COORD_BITS-1:0]  hit_y_o,
  input logic signed [COORD_BITS-1:0]  hit_z_o
);
  import rti_pkg::*;

  `RTI_ASSERT_ALWAYS(a_rst_no_out, !rst_ni |-> !out_valid_o, "result valid in reset")
  `RTI_ASSERT(a_stall_link, in_stall_o == (out_valid_o && out_stall_i), "stall link broken")
  `RTI_ASSERT(a_hold_valid, out_valid_o && out_stall_i |=> out_valid_o, "stalled result lost")
  `RTI_ASSERT(a_miss_zero, out_valid_o && !hit_o |-> dist_res_o == '0 && bary_u_o == '0 && bary_v_o == '0 && hit_x_o == '0 && hit_y_o == '0 && hit_z_o == '0, "miss not zeroed")
  `RTI_ASSERT(a_hit_bary, out_valid_o && hit_o |-> ({1'b0, bary_u_o} + {1'b0, bary_v_o}) <= (UVW+1)'(1 << UV_BITS) && dist_res_o >= 0, "hit out of range")
endmodule

bind ray_triangle_intersect_top rti_checker #(.COORD_BITS(COORD_BITS)) u_rti_checker (.*);

[test/ray_triangle_intersect_top_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for ray_triangle_intersect_top: directed and random rays
// against several triangles, checked by an in-bench Moller-Trumbore predictor.
// Depends on rti_pkg and the block itself.
module ray_triangle_intersect_top_test;
  import rti_pkg::*;

  localparam int CW = 20;
  localparam int FB = 10;
  localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint CMIN = -(64'sd1 <<< (CW - 1));
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] t_res;
    logic [UVW-1:0]       u;
    logic [UVW-1:0]       v;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [CW-1:0] pz;
  } hit_rec_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DW-1:0] cfg_data_i;
  logic in_valid_i, in_stall_o;
  logic signed [CW-1:0] origin_x_i, origin_y_i, origin_z_i, dir_x_i, dir_y_i, dir_z_i;
  logic out_valid_o, out_stall_i;
  logic hit_o;
  logic signed [CW-1:0] dist_res_o, hit_x_o, hit_y_o, hit_z_o;
  logic [UVW-1:0] bary_u_o, bary_v_o;

  ray_triangle_intersect_top u_top (.*);

  // triangle model
  logic [3*CW-1:0] tri_a, tri_b, tri_c;
  logic [EPS_BITS-1:0] eps_reg;
  logic cull_reg;

  hit_rec_t hit_q[$];
  int errors, rays_sent, results_seen, hits_seen, idle_cycles, rx_busy;
  bit jitter, hold_req;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint coord(logic [3*CW-1:0] r, int i);
    return longint'($signed(r[i*CW +: CW]));
  endfunction

  function automatic longint unsigned frac_div(longint unsigned num, longint unsigned den,
                                               int bits);
    longint unsigned q, rem;
    q = num / den;
    rem = num % den;
    if (q > (64'd1 << 40)) q = 64'd1 << 40;
    for (int i = 0; i < bits; i++) begin
      q = q << 1;
      rem = rem << 1;
      if (rem >= den) begin
        rem -= den;
        q |= 1;
      end
    end
    return q;
  endfunction

  function automatic longint clip(longint x);
    return (x > CMAX) ? CMAX : (x < CMIN) ? CMIN : x;
  endfunction

  function automatic hit_rec_t trace_ray(longint o[3], longint k[3]);
    hit_rec_t r;
    longint a[3], e1[3], e2[3], t[3], p[3], q[3];
    longint det, un, vn, tn, eps_det, acc;
    longint unsigned tq, uq, vq;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      a[i] = coord(tri_a, i);
      e1[i] = coord(tri_b, i) - a[i];
      e2[i] = coord(tri_c, i) - a[i];
      t[i] = o[i] - a[i];
    end
    p[0] = (k[1] * e2[2] - k[2] * e2[1]) >>> FB;
    p[1] = (k[2] * e2[0] - k[0] * e2[2]) >>> FB;
    p[2] = (k[0] * e2[1] - k[1] * e2[0]) >>> FB;
    q[0] = (t[1] * e1[2] - t[2] * e1[1]) >>> FB;
    q[1] = (t[2] * e1[0] - t[0] * e1[2]) >>> FB;
    q[2] = (t[0] * e1[1] - t[1] * e1[0]) >>> FB;
    det = e1[0] * p[0] + e1[1] * p[1] + e1[2] * p[2];
    un = t[0] * p[0] + t[1] * p[1] + t[2] * p[2];
    vn = k[0] * q[0] + k[1] * q[1] + k[2] * q[2];
    tn = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
    eps_det = longint'(eps_reg) <<< FB;
    if (cull_reg) begin
      if (det < eps_det) return r;
    end else if (det > -eps_det && det < eps_det) begin
      return r;
    end
    if (det == 0) return r;
    if (det < 0) begin
      det = -det; un = -un; vn = -vn; tn = -tn;
    end
    if (un < 0 || un > det || vn < 0 || un + vn > det || tn < 0) return r;
    tq = frac_div(tn, det, FB);
    if (tq < eps_reg) return r;
    uq = frac_div(un, det, UV_BITS);
    vq = frac_div(vn, det, UV_BITS);
    r.hit = 1'b1;
    r.t_res = (tq > CMAX) ? CMAX[CW-1:0] : tq[CW-1:0];
    r.u = uq[UVW-1:0];
    r.v = vq[UVW-1:0];
    acc = longint'(uq) * e1[0] + longint'(vq) * e2[0];
    r.px = CW'(clip(a[0] + ((acc + (64'sd1 <<< (UV_BITS - 1))) >>> UV_BITS)));
    acc = longint'(uq) * e1[1] + longint'(vq) * e2[1];
    r.py = CW'(clip(a[1] + ((acc + (64'sd1 <<< (UV_BITS - 1))) >>> UV_BITS)));
    acc = longint'(uq) * e1[2] + longint'(vq) * e2[2];
    r.pz = CW'(clip(a[2] + ((acc + (64'sd1 <<< (UV_BITS - 1))) >>> UV_BITS)));
    return r;
  endfunction

  task automatic wait_drained();
    wait (hit_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DW-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_VTX_A: tri_a = data[3*CW-1:0];
      CFG_VTX_B: tri_b = data[3*CW-1:0];
      CFG_VTX_C: tri_c = data[3*CW-1:0];
      CFG_EPS:   eps_reg = data[EPS_BITS-1:0];
      CFG_CULL:  cull_reg = data[0];
      default: ;
    endcase
  endtask

  task automatic set_triangle(longint a[3], longint b[3], longint c[3]);
    write_reg(CFG_VTX_A, {a[2][CW-1:0], a[1][CW-1:0], a[0][CW-1:0]});
    write_reg(CFG_VTX_B, {b[2][CW-1:0], b[1][CW-1:0], b[0][CW-1:0]});
    write_reg(CFG_VTX_C, {c[2][CW-1:0], c[1][CW-1:0], c[0][CW-1:0]});
  endtask

  // send one ray; valid stays high into the next call when there is no gap
  task automatic send_ray(longint o[3], longint k[3]);
    longint ob[3], kb[3];
    int r;
    for (int i = 0; i < 3; i++) begin
      ob[i] = longint'($signed(o[i][CW-1:0]));
      kb[i] = longint'($signed(k[i][CW-1:0]));
    end
    in_valid_i <= 1'b1;
    origin_x_i <= ob[0][CW-1:0]; origin_y_i <= ob[1][CW-1:0]; origin_z_i <= ob[2][CW-1:0];
    dir_x_i <= kb[0][CW-1:0]; dir_y_i <= kb[1][CW-1:0]; dir_z_i <= kb[2][CW-1:0];
    hit_q.push_back(trace_ray(ob, kb));
    do @(posedge clk_i); while (in_stall_o);
    rays_sent++;
    r = $urandom_range(0, 99);
    if (jitter && r < 25) begin
      in_valid_i <= 1'b0;
      repeat ((r < 3) ? $urandom_range(15, 60) : $urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic idle_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic longint rnd_full();
    return longint'($signed(20'($urandom)));
  endfunction

  function automatic longint rnd_span(int span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic random_triangle();
    longint a[3], b[3], c[3];
    for (int i = 0; i < 3; i++) begin
      a[i] = rnd_span(65536); b[i] = rnd_span(65536); c[i] = rnd_span(65536);
    end
    set_triangle(a, b, c);
  endtask

  // aim at a point near the triangle, or send noise
  task automatic random_ray();
    longint o[3], k[3], a[3], e1[3], e2[3];
    longint u, v;
    int sc;
    if ($urandom_range(0, 99) < 20) begin
      for (int i = 0; i < 3; i++) begin
        o[i] = rnd_full(); k[i] = rnd_full();
      end
    end else begin
      u = $urandom_range(0, 1100);
      v = $urandom_range(0, 1100 - u);
      sc = $urandom_range(0, 3);
      for (int i = 0; i < 3; i++) begin
        a[i] = coord(tri_a, i);
        e1[i] = coord(tri_b, i) - a[i];
        e2[i] = coord(tri_c, i) - a[i];
        o[i] = rnd_span(65536);
        k[i] = a[i] + (u * e1[i] + v * e2[i]) / 1024 - o[i];
        if (sc == 0) k[i] = k[i] / 2;
        else if (sc == 1) k[i] = k[i] / 64;
      end
    end
    send_ray(o, k);
  endtask

  task automatic test_reset_config();
    longint o[3], k[3];
    for (int n = 0; n < 4; n++) begin
      for (int i = 0; i < 3; i++) begin
        o[i] = rnd_full(); k[i] = rnd_full();
      end
      send_ray(o, k);
    end
    idle_input();
    wait_drained();
  endtask

  task automatic test_directed();
    longint a[3] = '{0, 0, 0}, b[3] = '{1024, 0, 0}, c[3] = '{0, 1024, 0};
    longint o[3], k[3];
    set_triangle(a, b, c);
    write_reg(CFG_EPS, CFG_DW'(1));
    write_reg(CFG_CULL, CFG_DW'(0));
    o = '{256, 256, -1024}; k = '{0, 0, 1024}; send_ray(o, k);       // front hit
    o = '{256, 256, 1024}; k = '{0, 0, -1024}; send_ray(o, k);       // back face
    o = '{0, 0, -1024}; k = '{0, 0, 1024}; send_ray(o, k);           // corner
    o = '{1024, 0, -1024}; k = '{0, 0, 1024}; send_ray(o, k);        // u edge
    o = '{512, 512, -1024}; k = '{0, 0, 1024}; send_ray(o, k);       // hypotenuse
    o = '{600, 600, -1024}; k = '{0, 0, 1024}; send_ray(o, k);       // outside
    o = '{256, 256, 1024}; k = '{0, 0, 1024}; send_ray(o, k);        // behind
    o = '{256, 256, 0}; k = '{0, 0, 1024}; send_ray(o, k);           // on plane
    o = '{256, 256, -1024}; k = '{1024, 0, 0}; send_ray(o, k);       // parallel
    o = '{256, 256, -524288}; k = '{0, 0, 1}; send_ray(o, k);        // saturated t
    o = '{CMIN, CMAX, CMIN}; k = '{CMAX, CMIN, CMAX}; send_ray(o, k);
    o = '{CMAX, CMIN, CMAX}; k = '{CMIN, CMAX, CMIN}; send_ray(o, k);
    idle_input();
    wait_drained();
    write_reg(CFG_CULL, CFG_DW'(1));
    o = '{256, 256, -1024}; k = '{0, 0, 1024}; send_ray(o, k);
    o = '{256, 256, 1024}; k = '{0, 0, -1024}; send_ray(o, k);
    idle_input();
    wait_drained();
    write_reg(CFG_CULL, CFG_DW'(0));
    write_reg(CFG_EPS, CFG_DW'(0));
    o = '{256, 256, 0}; k = '{0, 0, 1024}; send_ray(o, k);
    o = '{256, 256, -1024}; k = '{1024, 0, 0}; send_ray(o, k);
    idle_input();
    wait_drained();
    write_reg(CFG_EPS, CFG_DW'((1 << EPS_BITS) - 1));
    o = '{256, 256, -1024}; k = '{0, 0, 1024}; send_ray(o, k);
    idle_input();
    wait_drained();
    write_reg(CFG_UNUSED, {CFG_DW{1'b1}});
    write_reg(CFG_EPS, CFG_DW'(1));
    a = '{CMAX, CMIN, CMAX}; b = '{CMIN, CMAX, CMIN}; c = '{CMIN, CMIN, CMAX};
    set_triangle(a, b, c);
    o = '{0, 0, 0}; k = '{CMAX, CMAX, CMAX}; send_ray(o, k);
    o = '{CMIN, CMIN, CMIN}; k = '{CMAX, 1, CMAX}; send_ray(o, k);
    idle_input();
    wait_drained();
  endtask

  task automatic test_random(int n, logic [EPS_BITS-1:0] eps, bit cull);
    random_triangle();
    write_reg(CFG_EPS, CFG_DW'(eps));
    write_reg(CFG_CULL, CFG_DW'(cull));
    repeat (n) random_ray();
    idle_input();
    wait_drained();
  endtask

  task automatic test_back_pressure();
    random_triangle();
    hold_req = 1'b1;
    repeat (120) random_ray();
    idle_input();
    wait (hit_q.size() == 0);
    repeat (60) random_ray();
    idle_input();
    wait_drained();
  endtask

  // receiver: random stalls, occasional long hold
  always @(posedge clk_i) begin
    int r;
    r = $urandom_range(0, 99);
    if (hold_req) begin
      hold_req = 1'b0;
      rx_busy = 300;
    end
    if (rx_busy > 0) begin
      rx_busy--;
      out_stall_i <= 1'b1;
    end else if (jitter && r < 2) begin
      rx_busy = $urandom_range(10, 50);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= jitter && r < 20;
    end
  end

  always @(posedge clk_i) begin
    hit_rec_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (hit_q.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        e = hit_q.pop_front();
        hits_seen += e.hit;
        if (hit_o !== e.hit) begin
          $error("hit: expected %0d got %0d", e.hit, hit_o); errors++;
        end
        if (dist_res_o !== e.t_res) begin
          $error("dist_res: expected %0d got %0d", e.t_res, dist_res_o); errors++;
        end
        if (bary_u_o !== e.u) begin
          $error("bary_u: expected %0d got %0d", e.u, bary_u_o); errors++;
        end
        if (bary_v_o !== e.v) begin
          $error("bary_v: expected %0d got %0d", e.v, bary_v_o); errors++;
        end
        if (hit_x_o !== e.px) begin
          $error("hit_x: expected %0d got %0d", e.px, hit_x_o); errors++;
        end
        if (hit_y_o !== e.py) begin
          $error("hit_y: expected %0d got %0d", e.py, hit_y_o); errors++;
        end
        if (hit_z_o !== e.pz) begin
          $error("hit_z: expected %0d got %0d", e.pz, hit_z_o); errors++;
        end
      end
    end
  end

  // watchdog: cycles with work pending and no transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (!in_valid_i && hit_q.size() == 0)) begin
      idle_cycles = 0;
    end else if (++idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    in_valid_i = 1'b0; out_stall_i = 1'b0;
    origin_x_i = '0; origin_y_i = '0; origin_z_i = '0;
    dir_x_i = '0; dir_y_i = '0; dir_z_i = '0;
    tri_a = '0; tri_b = '0; tri_c = '0; eps_reg = EPS_BITS'(1); cull_reg = 1'b0;
    errors = 0; rays_sent = 0; results_seen = 0; hits_seen = 0;
    idle_cycles = 0; rx_busy = 0; jitter = 1'b0; hold_req = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_config();
    test_directed();
    test_random(200, EPS_BITS'(1), 1'b0);
    jitter = 1'b1;
    test_random(300, EPS_BITS'(1), 1'b1);
    test_random(300, EPS_BITS'(0), 1'b0);
    test_random(250, EPS_BITS'(16), 1'b1);
    test_back_pressure();
    test_random(250, EPS_BITS'(1024), 1'b0);
    test_random(100, EPS_BITS'((1 << EPS_BITS) - 1), 1'b0);
    jitter = 1'b0;
    test_random(250, EPS_BITS'(2), 1'b0);
    wait (hit_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d rays, %0d results, %0d hits, across culling and epsilon settings.",
             rays_sent, results_seen, hits_seen);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
